[sv/source_route_node_table_defines.svh]
// ----------------------------------------------------------------------------
// Source route node table: assertion macros
// Shared property shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef SOURCE_ROUTE_NODE_TABLE_DEFINES_SVH
`define SOURCE_ROUTE_NODE_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst
`define SRNT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define SRNT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/srnt_pkg.sv]
// ----------------------------------------------------------------------------
// Source route node table package
// Request and result item types, request and status codes, register indexes.
// ----------------------------------------------------------------------------
package srnt_pkg;

  // request codes
  localparam logic [2:0] REQ_UPDATE = 3'd0;
  localparam logic [2:0] REQ_EXPIRE = 3'd1;
  localparam logic [2:0] REQ_QUERY  = 3'd2;
  localparam logic [2:0] REQ_TICK   = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MATCH   = 2'd0;
  localparam logic [1:0] CFG_ROOT_HI = 2'd1;
  localparam logic [1:0] CFG_ROOT_LO = 2'd2;
  localparam logic [1:0] CFG_NOPATH  = 2'd3;

  // infinite lifetime
  localparam logic [31:0] LIFE_INF = 32'hffff_ffff;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic        has_parent;
    logic [63:0] par_hi;
    logic [63:0] par_lo;
    logic [31:0] new_lifetime;
    logic [4:0]  slot_sel;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        reachable;
    logic [5:0]  node_count;
    logic        slot_used;
    logic [63:0] slot_addr_hi;
    logic [63:0] slot_addr_lo;
    logic [5:0]  slot_parent;
    logic [31:0] slot_lifetime;
  } rsp_t;

endpackage

[sv/srnt_ram.sv]
// ----------------------------------------------------------------------------
// Source route node table entry memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module srnt_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 166
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, read data registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[sv/source_route_node_table.sv]
// ----------------------------------------------------------------------------
// Source route node table
// Node table for one routing DAG: parent links, lifetimes, reachability.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with an item on req while busy is low; the item is taken at
//   that edge. Exactly one result item appears on rsp with done high for one
//   cycle; the receiver cannot stall, so it must take it then. busy stays
//   high from the accepting edge through the done cycle.
//   Registers are written on the cfg channel (cfg_ready is always high);
//   write them only while busy is low; the block does not enforce it.
// Operation (D = TABLE_DEPTH): every step goes through the entry memory,
//   which has one write port and one read port. A lookup scans slots at one
//   per cycle; a reachability check is two lookups plus up to D parent
//   reads. Tick is an aging pass, then a pass over the slots with a child
//   scan for each slot whose lifetime reaches zero.
// Reset: rst clears all slots to unused, node count to zero and the
//   registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module source_route_node_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  srnt_pkg::req_t req,
  output logic          done,
  output srnt_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [63:0]   cfg_data
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int SW = $clog2(TABLE_DEPTH + 1);
  localparam logic [SW-1:0] NO_SLOT = SW'(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST    = IW'(TABLE_DEPTH - 1);

  typedef struct packed {
    logic [63:0]   hi;
    logic [63:0]   lo;
    logic [SW-1:0] parent;
    logic [31:0]   life;
  } ent_t;

  typedef enum logic [23:0] {
    S_IDLE = 24'h000001,
    S_CMD  = 24'h000002,
    S_LK   = 24'h000004,
    S_RC_N = 24'h000008,
    S_RC_R = 24'h000010,
    S_RC_W = 24'h000020,
    S_WK   = 24'h000040,
    S_WK2  = 24'h000080,
    S_U1   = 24'h000100,
    S_U2   = 24'h000200,
    S_U3   = 24'h000400,
    S_U4   = 24'h000800,
    S_U5   = 24'h001000,
    S_U6   = 24'h002000,
    S_E1   = 24'h004000,
    S_E2   = 24'h008000,
    S_Q1   = 24'h010000,
    S_Q2   = 24'h020000,
    S_T1   = 24'h040000,
    S_T2   = 24'h080000,
    S_T3   = 24'h100000,
    S_T4   = 24'h200000,
    S_R1   = 24'h400000,
    S_DONE = 24'h800000
  } state_t;

  function automatic logic [5:0] low6(input logic [SW-1:0] v);
    logic [SW+5:0] w;
    w = (SW+6)'(v);
    return w[5:0];
  endfunction

  function automatic srnt_pkg::rsp_t with_slot(input srnt_pkg::rsp_t r,
                                                input logic [63:0] hi,
                                                input logic [63:0] lo,
                                                input logic [SW-1:0] par,
                                                input logic [31:0] life);
    r.slot_used     = 1'b1;
    r.slot_addr_hi  = hi;
    r.slot_addr_lo  = lo;
    r.slot_parent   = low6(par);
    r.slot_lifetime = life;
    return r;
  endfunction

  function automatic srnt_pkg::rsp_t with_status(input srnt_pkg::rsp_t r,
                                                  input logic [1:0] st);
    r.status = st;
    return r;
  endfunction

  // empty result: no slot shown
  function automatic srnt_pkg::rsp_t blank_rsp();
    srnt_pkg::rsp_t r;
    r             = '0;
    r.slot_parent = low6(NO_SLOT);
    return r;
  endfunction

  // control
  state_t               state, lk_ret, rc_ret;
  logic [TABLE_DEPTH-1:0] used;
  logic [SW-1:0]        count;
  logic [SW-1:0]        cnt;
  logic                 chk_vld;
  logic [IW-1:0]        chk_idx;

  // configuration
  logic                 match_en;
  logic [63:0]          root_hi, root_lo;
  logic [31:0]          nopath;

  // payload and working registers
  srnt_pkg::req_t       rq;
  srnt_pkg::rsp_t       res;
  logic [63:0]          key_hi, key_lo;
  logic [SW-1:0]        lk_res;
  ent_t                 lk_ent;
  logic [SW-1:0]        cslot, pslot, old_par;
  logic [SW-1:0]        wn, wr, steps;
  logic                 rc_res;
  logic [SW-1:0]        tslot;

  // memory port
  logic                 ram_we;
  logic [IW-1:0]        ram_waddr, ram_raddr;
  ent_t                 ram_wdata;
  logic [$bits(ent_t)-1:0] ram_rdata;
  ent_t                 rent;

  // helpers
  logic                 free_vld;
  logic [IW-1:0]        free_idx;
  logic [SW+4:0]        sel_w;
  logic                 scanning;
  logic                 e_match;

  assign rent      = ent_t'(ram_rdata);
  assign sel_w     = (SW+5)'(rq.slot_sel);
  assign scanning  = (state == S_LK) || (state == S_T1) || (state == S_T4);
  assign e_match   = (rent.hi == rq.par_hi) && (rent.lo == rq.par_lo);
  assign busy      = (state != S_IDLE);
  assign done      = (state == S_DONE);
  assign cfg_ready = 1'b1;

  // lowest free slot
  always_comb begin
    free_vld = 1'b0;
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_vld = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // result item
  always_comb begin
    rsp            = res;
    rsp.node_count = low6(count);
  end

  srnt_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH ($bits(ent_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // memory address and write selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cslot[IW-1:0];
    ram_wdata = '0;
    ram_raddr = cnt[IW-1:0];
    case (state)
      S_CMD: begin
        ram_raddr = sel_w[IW-1:0];
      end
      S_WK: begin
        ram_raddr = wn[IW-1:0];
      end
      S_E1: begin
        ram_raddr = lk_ent.parent[IW-1:0];
      end
      S_T2: begin
        ram_raddr = tslot[IW-1:0];
      end
      S_T1: begin
        // age a finite nonzero lifetime
        if (chk_vld && used[chk_idx] && rent.life != srnt_pkg::LIFE_INF &&
            rent.life != 32'd0) begin
          ram_we         = 1'b1;
          ram_waddr      = chk_idx;
          ram_wdata      = rent;
          ram_wdata.life = rent.life - 32'd1;
        end
      end
      S_U2: begin
        // create a missing parent
        if (lk_res == NO_SLOT && free_vld) begin
          ram_we    = 1'b1;
          ram_waddr = free_idx;
          ram_wdata = '{hi: rq.par_hi, lo: rq.par_lo, parent: NO_SLOT,
                        life: srnt_pkg::LIFE_INF};
        end
      end
      S_U4: begin
        ram_we    = 1'b1;
        ram_wdata = '{hi: rq.addr_hi, lo: rq.addr_lo, parent: old_par,
                      life: rq.new_lifetime};
      end
      S_U5: begin
        ram_we    = 1'b1;
        ram_wdata = '{hi: rq.addr_hi, lo: rq.addr_lo, parent: pslot,
                      life: rq.new_lifetime};
      end
      S_U6: begin
        // revert when the new parent broke reachability
        ram_we    = !rc_res;
        ram_wdata = '{hi: rq.addr_hi, lo: rq.addr_lo, parent: old_par,
                      life: rq.new_lifetime};
      end
      S_E2: begin
        ram_we         = e_match;
        ram_wdata      = lk_ent;
        ram_wdata.life = nopath;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      lk_ret   <= S_IDLE;
      rc_ret   <= S_IDLE;
      used     <= '0;
      count    <= '0;
      cnt      <= '0;
      chk_vld  <= 1'b0;
      match_en <= 1'b1;
      root_hi  <= '0;
      root_lo  <= '0;
      nopath   <= 32'd60;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          srnt_pkg::CFG_MATCH:   match_en <= cfg_data[0];
          srnt_pkg::CFG_ROOT_HI: root_hi  <= cfg_data;
          srnt_pkg::CFG_ROOT_LO: root_lo  <= cfg_data;
          srnt_pkg::CFG_NOPATH:  nopath   <= cfg_data[31:0];
          default: begin
          end
        endcase
      end

      // scan counter rests outside scanning states
      if (!scanning) begin
        cnt     <= '0;
        chk_vld <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            rq    <= req;
            res   <= blank_rsp();
            state <= S_CMD;
          end
        end

        S_CMD: begin
          key_hi <= rq.addr_hi;
          key_lo <= rq.addr_lo;
          case (rq.req_type)
            srnt_pkg::REQ_UPDATE: begin
              lk_ret <= S_U1;
              state  <= S_LK;
            end
            srnt_pkg::REQ_EXPIRE: begin
              lk_ret <= S_E1;
              state  <= S_LK;
            end
            srnt_pkg::REQ_QUERY: begin
              lk_ret <= S_Q1;
              state  <= S_LK;
            end
            srnt_pkg::REQ_TICK: begin
              state <= S_T1;
            end
            srnt_pkg::REQ_READ: begin
              if (sel_w >= (SW+5)'(TABLE_DEPTH)) begin
                res.status <= srnt_pkg::ST_NONE;
                state      <= S_DONE;
              end else if (used[sel_w[IW-1:0]]) begin
                state <= S_R1;
              end else begin
                state <= S_DONE;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end

        // lookup: first used slot whose address equals the key, none while match_en is low
        S_LK: begin
          if (!match_en) begin
            lk_res <= NO_SLOT;
            state  <= lk_ret;
          end else if (chk_vld && used[chk_idx] && rent.hi == key_hi &&
                       rent.lo == key_lo) begin
            lk_res <= SW'(chk_idx);
            lk_ent <= rent;
            state  <= lk_ret;
          end else if (chk_vld && chk_idx == LAST) begin
            lk_res <= NO_SLOT;
            state  <= lk_ret;
          end else begin
            chk_vld <= (cnt < NO_SLOT);
            chk_idx <= cnt[IW-1:0];
            if (cnt < NO_SLOT) begin
              cnt <= cnt + 1'b1;
            end
          end
        end

        // reachability: node slot, root slot, then walk parents
        S_RC_N: begin
          key_hi <= rq.addr_hi;
          key_lo <= rq.addr_lo;
          lk_ret <= S_RC_R;
          state  <= S_LK;
        end
        S_RC_R: begin
          wn     <= lk_res;
          key_hi <= root_hi;
          key_lo <= root_lo;
          lk_ret <= S_RC_W;
          state  <= S_LK;
        end
        S_RC_W: begin
          wr    <= lk_res;
          steps <= NO_SLOT;
          state <= S_WK;
        end
        S_WK: begin
          if (wn < NO_SLOT && wn != wr && steps != '0) begin
            state <= S_WK2;
          end else begin
            rc_res <= (wn < NO_SLOT) && (wn == wr);
            state  <= rc_ret;
          end
        end
        S_WK2: begin
          wn    <= rent.parent;
          steps <= steps - 1'b1;
          state <= S_WK;
        end

        // update link
        S_U1: begin
          cslot   <= lk_res;
          old_par <= lk_ent.parent;
          if (rq.has_parent) begin
            key_hi <= rq.par_hi;
            key_lo <= rq.par_lo;
            lk_ret <= S_U2;
            state  <= S_LK;
          end else begin
            pslot <= NO_SLOT;
            state <= S_U3;
          end
        end
        S_U2: begin
          if (lk_res != NO_SLOT) begin
            pslot <= lk_res;
            state <= S_U3;
          end else if (free_vld) begin
            used[free_idx] <= 1'b1;
            count          <= count + 1'b1;
            pslot          <= SW'(free_idx);
            state          <= S_U3;
          end else begin
            res.status <= srnt_pkg::ST_FULL;
            state      <= S_DONE;
          end
        end
        S_U3: begin
          if (cslot != NO_SLOT) begin
            state <= S_U4;
          end else if (free_vld) begin
            used[free_idx] <= 1'b1;
            count          <= count + 1'b1;
            cslot          <= SW'(free_idx);
            old_par        <= NO_SLOT;
            state          <= S_U4;
          end else begin
            res.status <= srnt_pkg::ST_FULL;
            state      <= S_DONE;
          end
        end
        S_U4: begin
          rc_ret <= S_U5;
          state  <= S_RC_N;
        end
        S_U5: begin
          if (rc_res) begin
            rc_ret <= S_U6;
            state  <= S_RC_N;
          end else begin
            res   <= with_slot(res, rq.addr_hi, rq.addr_lo, pslot, rq.new_lifetime);
            state <= S_DONE;
          end
        end
        S_U6: begin
          res   <= with_slot(res, rq.addr_hi, rq.addr_lo, rc_res ? pslot : old_par,
                             rq.new_lifetime);
          state <= S_DONE;
        end

        // expire link
        S_E1: begin
          cslot <= lk_res;
          if (lk_res == NO_SLOT) begin
            res.status <= srnt_pkg::ST_NONE;
            state      <= S_DONE;
          end else if (rq.has_parent && lk_ent.parent < NO_SLOT) begin
            state <= S_E2;
          end else begin
            res   <= with_status(with_slot(res, lk_ent.hi, lk_ent.lo, lk_ent.parent,
                                           lk_ent.life), srnt_pkg::ST_NONE);
            state <= S_DONE;
          end
        end
        S_E2: begin
          if (e_match) begin
            res <= with_slot(res, lk_ent.hi, lk_ent.lo, lk_ent.parent, nopath);
          end else begin
            res <= with_status(with_slot(res, lk_ent.hi, lk_ent.lo, lk_ent.parent,
                                         lk_ent.life), srnt_pkg::ST_NONE);
          end
          state <= S_DONE;
        end

        // reachability query
        S_Q1: begin
          if (lk_res == NO_SLOT) begin
            res.status <= srnt_pkg::ST_NONE;
            state      <= S_DONE;
          end else begin
            res    <= with_slot(res, lk_ent.hi, lk_ent.lo, lk_ent.parent, lk_ent.life);
            rc_ret <= S_Q2;
            state  <= S_RC_N;
          end
        end
        S_Q2: begin
          res.reachable <= rc_res;
          state         <= S_DONE;
        end

        // tick: aging pass, then free childless expired slots in order
        S_T1: begin
          if (chk_vld && chk_idx == LAST) begin
            tslot <= '0;
            state <= S_T2;
          end else begin
            chk_vld <= (cnt < NO_SLOT);
            chk_idx <= cnt[IW-1:0];
            if (cnt < NO_SLOT) begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_T2: begin
          if (tslot == NO_SLOT) begin
            state <= S_DONE;
          end else begin
            state <= S_T3;
          end
        end
        S_T3: begin
          if (used[tslot[IW-1:0]] && rent.life == 32'd0) begin
            state <= S_T4;
          end else begin
            tslot <= tslot + 1'b1;
            state <= S_T2;
          end
        end
        S_T4: begin
          if (chk_vld && used[chk_idx] && rent.parent == tslot) begin
            tslot <= tslot + 1'b1;
            state <= S_T2;
          end else if (chk_vld && chk_idx == LAST) begin
            used[tslot[IW-1:0]] <= 1'b0;
            count               <= count - 1'b1;
            tslot               <= tslot + 1'b1;
            state               <= S_T2;
          end else begin
            chk_vld <= (cnt < NO_SLOT);
            chk_idx <= cnt[IW-1:0];
            if (cnt < NO_SLOT) begin
              cnt <= cnt + 1'b1;
            end
          end
        end

        // read slot
        S_R1: begin
          res   <= with_slot(res, rent.hi, rent.lo, rent.parent, rent.life);
          state <= S_DONE;
        end

        S_DONE: begin
          state <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/srnt_checker.sv]
// ----------------------------------------------------------------------------
// Source route node table checker
// Port-level properties of the command and result channels.
// ----------------------------------------------------------------------------
`include "source_route_node_table_defines.svh"

module srnt_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input srnt_pkg::rsp_t rsp
);

  // result only while an item is in flight
  `SRNT_ASSERT_NOW(a_done_busy, done, busy, "done without busy")

  // an accepted item holds the block busy, no same-cycle result
  `SRNT_ASSERT_NEXT(a_accept, start && !busy, busy && !done, "accept not followed by busy")

  // one result per item, then ready again
  `SRNT_ASSERT_NEXT(a_one_result, done, !done && !busy, "result not a single pulse")

  // a full table reports no slot
  `SRNT_ASSERT_NOW(a_full, done && rsp.status == srnt_pkg::ST_FULL,
                   !rsp.slot_used && !rsp.reachable, "full status with slot data")

  // reachable only for a found node
  `SRNT_ASSERT_NOW(a_reach, done && rsp.reachable,
                   rsp.status == srnt_pkg::ST_OK && rsp.slot_used, "reachable without node")

endmodule

bind source_route_node_table srnt_checker u_srnt_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Source route node table testbench
// Drives random and directed table requests through the command port, predicts
// every result item from a behavioral copy of the table and checks each one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// Expected result store and comparison
class route_result_board;
  srnt_pkg::rsp_t pending[$];
  int   errors;
  int   checked;

  function new();
    errors  = 0;
    checked = 0;
  endfunction

  function void note_request(srnt_pkg::rsp_t exp_rsp);
    pending.push_back(exp_rsp);
  endfunction

  function void check_result(srnt_pkg::rsp_t got);
    srnt_pkg::rsp_t exp_rsp;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result item %h", $realtime, got);
      errors++;
      return;
    end
    exp_rsp = pending.pop_front();
    checked++;
    if (got.status !== exp_rsp.status) begin
      $display("%0t: status exp %0d got %0d", $realtime, exp_rsp.status, got.status);
      errors++;
    end
    if (got.reachable !== exp_rsp.reachable) begin
      $display("%0t: reachable exp %0d got %0d", $realtime, exp_rsp.reachable,
               got.reachable);
      errors++;
    end
    if (got.node_count !== exp_rsp.node_count) begin
      $display("%0t: node_count exp %0d got %0d", $realtime, exp_rsp.node_count,
               got.node_count);
      errors++;
    end
    if (got.slot_used !== exp_rsp.slot_used) begin
      $display("%0t: slot_used exp %0d got %0d", $realtime, exp_rsp.slot_used,
               got.slot_used);
      errors++;
    end
    if (got.slot_addr_hi !== exp_rsp.slot_addr_hi) begin
      $display("%0t: slot_addr_hi exp %h got %h", $realtime, exp_rsp.slot_addr_hi,
               got.slot_addr_hi);
      errors++;
    end
    if (got.slot_addr_lo !== exp_rsp.slot_addr_lo) begin
      $display("%0t: slot_addr_lo exp %h got %h", $realtime, exp_rsp.slot_addr_lo,
               got.slot_addr_lo);
      errors++;
    end
    if (got.slot_parent !== exp_rsp.slot_parent) begin
      $display("%0t: slot_parent exp %0d got %0d", $realtime, exp_rsp.slot_parent,
               got.slot_parent);
      errors++;
    end
    if (got.slot_lifetime !== exp_rsp.slot_lifetime) begin
      $display("%0t: slot_lifetime exp %h got %h", $realtime, exp_rsp.slot_lifetime,
               got.slot_lifetime);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int DEPTH = 32;
  localparam logic [5:0] NO_PARENT = 6'd32;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  srnt_pkg::req_t req;
  logic done;
  srnt_pkg::rsp_t rsp;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [63:0] cfg_data;

  source_route_node_table #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Table shadow
  logic        t_used   [DEPTH];
  logic [63:0] t_hi     [DEPTH];
  logic [63:0] t_lo     [DEPTH];
  logic [5:0]  t_par    [DEPTH];
  logic [31:0] t_life   [DEPTH];
  int          t_count;
  logic        m_enable;
  logic [63:0] m_root_hi;
  logic [63:0] m_root_lo;
  logic [31:0] m_nopath;

  route_result_board board;
  int n_items;

  // Address pool so lookups hit
  logic [63:0] pool_hi [8];
  logic [63:0] pool_lo [8];

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic int find_slot(logic [63:0] hi, logic [63:0] lo);
    if (!m_enable) return DEPTH;
    for (int i = 0; i < DEPTH; i++)
      if (t_used[i] && t_hi[i] == hi && t_lo[i] == lo) return i;
    return DEPTH;
  endfunction

  function automatic bit walks_to_root(logic [63:0] hi, logic [63:0] lo);
    int n;
    int r;
    int steps;
    n = find_slot(hi, lo);
    r = find_slot(m_root_hi, m_root_lo);
    steps = DEPTH;
    while (n < DEPTH && n != r && steps > 0) begin
      n = int'(t_par[n]);
      steps--;
    end
    return n < DEPTH && n == r;
  endfunction

  function automatic int take_free_slot();
    for (int i = 0; i < DEPTH; i++)
      if (!t_used[i]) begin
        t_used[i] = 1'b1;
        t_par[i]  = NO_PARENT;
        t_count++;
        return i;
      end
    return DEPTH;
  endfunction

  function automatic void show_slot(ref srnt_pkg::rsp_t r, input int s);
    r.slot_used     = 1'b1;
    r.slot_addr_hi  = t_hi[s];
    r.slot_addr_lo  = t_lo[s];
    r.slot_parent   = t_par[s];
    r.slot_lifetime = t_life[s];
  endfunction

  // Predict one result and advance the shadow table
  function automatic srnt_pkg::rsp_t predict_table_op(srnt_pkg::req_t q);
    srnt_pkg::rsp_t r;
    int c;
    int p;
    logic [5:0] old;
    bit kid;
    bit fail;
    r = '0;
    r.slot_parent = NO_PARENT;
    fail = 0;
    case (q.req_type)
      srnt_pkg::REQ_UPDATE: begin
        c = find_slot(q.addr_hi, q.addr_lo);
        p = DEPTH;
        if (q.has_parent) begin
          p = find_slot(q.par_hi, q.par_lo);
          if (p == DEPTH) begin
            p = take_free_slot();
            if (p == DEPTH) fail = 1;
            else begin
              t_hi[p] = q.par_hi;
              t_lo[p] = q.par_lo;
              t_life[p] = srnt_pkg::LIFE_INF;
            end
          end
        end
        if (!fail && c == DEPTH) begin
          c = take_free_slot();
          if (c == DEPTH) fail = 1;
        end
        if (fail) r.status = srnt_pkg::ST_FULL;
        else begin
          t_life[c] = q.new_lifetime;
          t_hi[c] = q.addr_hi;
          t_lo[c] = q.addr_lo;
          if (walks_to_root(q.addr_hi, q.addr_lo)) begin
            old = t_par[c];
            t_par[c] = 6'(p);
            if (!walks_to_root(q.addr_hi, q.addr_lo)) t_par[c] = old;
          end else begin
            t_par[c] = 6'(p);
          end
          show_slot(r, c);
        end
      end
      srnt_pkg::REQ_EXPIRE: begin
        c = find_slot(q.addr_hi, q.addr_lo);
        if (c == DEPTH) r.status = srnt_pkg::ST_NONE;
        else begin
          p = int'(t_par[c]);
          if (q.has_parent && p < DEPTH && t_hi[p] == q.par_hi && t_lo[p] == q.par_lo)
            t_life[c] = m_nopath;
          else
            r.status = srnt_pkg::ST_NONE;
          show_slot(r, c);
        end
      end
      srnt_pkg::REQ_QUERY: begin
        c = find_slot(q.addr_hi, q.addr_lo);
        if (c == DEPTH) r.status = srnt_pkg::ST_NONE;
        else begin
          r.reachable = walks_to_root(q.addr_hi, q.addr_lo);
          show_slot(r, c);
        end
      end
      srnt_pkg::REQ_TICK: begin
        for (int i = 0; i < DEPTH; i++)
          if (t_used[i] && t_life[i] != srnt_pkg::LIFE_INF && t_life[i] != 0)
            t_life[i] = t_life[i] - 32'd1;
        // free childless expired slots in slot order
        for (int i = 0; i < DEPTH; i++) begin
          if (t_used[i] && t_life[i] == 0) begin
            kid = 0;
            for (int j = 0; j < DEPTH; j++)
              if (t_used[j] && int'(t_par[j]) == i) kid = 1;
            if (!kid) begin
              t_used[i] = 1'b0;
              t_count--;
            end
          end
        end
      end
      srnt_pkg::REQ_READ: begin
        if (t_used[q.slot_sel]) show_slot(r, int'(q.slot_sel));
      end
      default: ;
    endcase
    r.node_count = t_count[5:0];
    return r;
  endfunction

  // Result monitor
  always @(posedge clk) begin
    if (!rst && done) board.check_result(rsp);
  end

  task automatic idle_gap();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return;
    repeat (k < 9 ? $urandom_range(1, 3) : $urandom_range(5, 40)) @(posedge clk);
  endtask

  task automatic send_item(srnt_pkg::req_t q);
    start <= 1'b1;
    req   <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    // taken at this edge
    board.note_request(predict_table_op(q));
    n_items++;
    start <= 1'b0;
    @(posedge clk);
    idle_gap();
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      srnt_pkg::CFG_MATCH:   m_enable  = val[0];
      srnt_pkg::CFG_ROOT_HI: m_root_hi = val;
      srnt_pkg::CFG_ROOT_LO: m_root_lo = val;
      srnt_pkg::CFG_NOPATH:  m_nopath  = val[31:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic srnt_pkg::req_t random_item(int pool_n);
    srnt_pkg::req_t q;
    int a;
    int b;
    q = '0;
    a = $urandom_range(0, pool_n - 1);
    b = $urandom_range(0, pool_n - 1);
    q.addr_hi = pool_hi[a];
    q.addr_lo = pool_lo[a];
    q.par_hi  = pool_hi[b];
    q.par_lo  = pool_lo[b];
    if ($urandom_range(0, 15) == 0) begin
      q.addr_hi = rand64();
      q.addr_lo = rand64();
    end
    if ($urandom_range(0, 15) == 0) begin
      q.par_hi = rand64();
      q.par_lo = rand64();
    end
    q.has_parent = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 3))
      0: q.new_lifetime = srnt_pkg::LIFE_INF;
      1: q.new_lifetime = $urandom();
      default: q.new_lifetime = $urandom_range(0, 4);
    endcase
    q.slot_sel = 5'($urandom());
    a = $urandom_range(0, 99);
    if (a < 40) q.req_type = srnt_pkg::REQ_UPDATE;
    else if (a < 52) q.req_type = srnt_pkg::REQ_EXPIRE;
    else if (a < 70) q.req_type = srnt_pkg::REQ_QUERY;
    else if (a < 85) q.req_type = srnt_pkg::REQ_TICK;
    else if (a < 97) q.req_type = srnt_pkg::REQ_READ;
    else q.req_type = 3'($urandom_range(5, 7));
    return q;
  endfunction

  initial begin
    srnt_pkg::req_t q;
    int phase_pool;
    board = new();
    n_items = 0;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = srnt_pkg::CFG_MATCH;
    cfg_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      t_used[i] = 0; t_hi[i] = 0; t_lo[i] = 0; t_par[i] = 0; t_life[i] = 0;
    end
    t_count = 0;
    m_enable = 1; m_root_hi = 0; m_root_lo = 0; m_nopath = 60;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: root at all zeros, extremes of addresses and lifetimes
    q = '0; q.req_type = srnt_pkg::REQ_QUERY; send_item(q);
    q = '0; q.req_type = srnt_pkg::REQ_UPDATE; q.has_parent = 1; q.addr_hi = '1;
    q.addr_lo = '1; q.new_lifetime = srnt_pkg::LIFE_INF; send_item(q);
    q.addr_hi = 64'h1; q.addr_lo = 64'h2; q.par_hi = '1; q.par_lo = '1;
    q.new_lifetime = 32'd1; send_item(q);
    q.req_type = srnt_pkg::REQ_QUERY; send_item(q);
    // move root-reaching node to a parent that breaks reachability: reverted
    q.req_type = srnt_pkg::REQ_UPDATE; q.par_hi = 64'h55; q.par_lo = 64'h66; send_item(q);
    q.req_type = srnt_pkg::REQ_EXPIRE; q.par_hi = '1; q.par_lo = '1; send_item(q);
    q.par_hi = 64'h77; send_item(q);
    q.has_parent = 0; send_item(q);
    q.req_type = srnt_pkg::REQ_UPDATE; q.new_lifetime = 32'd0; send_item(q);
    q.req_type = srnt_pkg::REQ_TICK; send_item(q);
    q.req_type = srnt_pkg::REQ_READ; q.slot_sel = 5'd0; send_item(q);
    q.slot_sel = 5'd31; send_item(q);
    q.slot_sel = 5'd1; send_item(q);
    q.req_type = 3'd7; send_item(q);
    q.req_type = 3'd5; send_item(q);
    // fill the table to reach the full status
    for (int i = 0; i < 34; i++) begin
      q = '0; q.req_type = srnt_pkg::REQ_UPDATE; q.addr_hi = 64'h100 + 64'(i);
      q.addr_lo = 64'(i);
      q.has_parent = ((i % 2) != 0); q.par_hi = 64'h900 + 64'(i); q.new_lifetime = 32'd1;
      send_item(q);
    end
    q.req_type = srnt_pkg::REQ_TICK; send_item(q); send_item(q);
    drain();

    // Random phases across register settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(srnt_pkg::CFG_NOPATH, 64'd0);
          write_reg(srnt_pkg::CFG_ROOT_HI, '1);
        end
        1: begin
          write_reg(srnt_pkg::CFG_NOPATH, 64'hffff_fffe);
          write_reg(srnt_pkg::CFG_ROOT_LO, '1);
        end
        2: begin
          write_reg(srnt_pkg::CFG_MATCH, 64'd0);
          write_reg(srnt_pkg::CFG_NOPATH, 64'd2);
        end
        3: begin
          write_reg(srnt_pkg::CFG_MATCH, 64'd1);
          write_reg(srnt_pkg::CFG_ROOT_HI, rand64());
          write_reg(srnt_pkg::CFG_ROOT_LO, rand64());
        end
        default: begin
          write_reg(srnt_pkg::CFG_NOPATH, 64'($urandom_range(0, 5)));
        end
      endcase
      phase_pool = (ph == 4) ? 8 : $urandom_range(3, 8);
      for (int i = 0; i < 8; i++) begin
        pool_hi[i] = rand64();
        pool_lo[i] = rand64();
      end
      pool_hi[0] = m_root_hi;
      pool_lo[0] = m_root_lo;
      for (int i = 0; i < 100; i++) send_item(random_item(phase_pool));
      drain();
    end

    $display("Ran %0d table requests over five register settings; %0d results checked.",
             n_items, board.checked);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("PASS source_route_node_table");
    else
      $display("FAIL source_route_node_table");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL source_route_node_table");
    $finish;
  end
endmodule

[source_route_node_table.f]
+incdir+sv
sv/srnt_pkg.sv
sv/srnt_ram.sv
sv/source_route_node_table.sv
sv/srnt_checker.sv
tb/tb.sv
